FILE: sv/s2a_pkg.sv
// s2a_pkg: shared types, scancode constants and key map tables for the
// set-1 scancode to ascii decoder; no dependencies

package s2a_pkg;

   // special set-1 scancodes
   localparam logic [7:0] SCAN_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] SCAN_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] SCAN_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] SCAN_RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] SCAN_CTRL_MAKE    = 8'h1D;
   localparam logic [7:0] SCAN_CTRL_BREAK   = 8'h9D;

   localparam int unsigned SCAN_W  = 8;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned TDATA_W = 16;

   typedef struct packed {
      logic ctrl;
      logic shift;
   } flags_type;

   typedef struct packed {
      logic              char_valid;
      logic [CHAR_W-1:0] ascii_char;
      flags_type         flags;
   } result_type;

   // unshifted us layout; codes 88 and up and release codes give 0
   function automatic logic [CHAR_W-1:0] plain_char(input logic [SCAN_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      unique case (code)
         8'd2:    ch = 7'h31; // 1
         8'd3:    ch = 7'h32;
         8'd4:    ch = 7'h33;
         8'd5:    ch = 7'h34;
         8'd6:    ch = 7'h35;
         8'd7:    ch = 7'h36;
         8'd8:    ch = 7'h37;
         8'd9:    ch = 7'h38;
         8'd10:   ch = 7'h39;
         8'd11:   ch = 7'h30; // 0
         8'd12:   ch = 7'h2D; // -
         8'd13:   ch = 7'h3D; // =
         8'd14:   ch = 7'h08; // backspace
         8'd15:   ch = 7'h09; // tab
         8'd16:   ch = 7'h71; // q
         8'd17:   ch = 7'h77;
         8'd18:   ch = 7'h65;
         8'd19:   ch = 7'h72;
         8'd20:   ch = 7'h74;
         8'd21:   ch = 7'h79;
         8'd22:   ch = 7'h75;
         8'd23:   ch = 7'h69;
         8'd24:   ch = 7'h6F;
         8'd25:   ch = 7'h70; // p
         8'd26:   ch = 7'h5B; // [
         8'd27:   ch = 7'h5D; // ]
         8'd28:   ch = 7'h0A; // enter
         8'd30:   ch = 7'h61; // a
         8'd31:   ch = 7'h73;
         8'd32:   ch = 7'h64;
         8'd33:   ch = 7'h66;
         8'd34:   ch = 7'h67;
         8'd35:   ch = 7'h68;
         8'd36:   ch = 7'h6A;
         8'd37:   ch = 7'h6B;
         8'd38:   ch = 7'h6C; // l
         8'd39:   ch = 7'h3B; // ;
         8'd40:   ch = 7'h27; // quote
         8'd41:   ch = 7'h60; // backtick
         8'd43:   ch = 7'h5C; // backslash
         8'd44:   ch = 7'h7A; // z
         8'd45:   ch = 7'h78;
         8'd46:   ch = 7'h63;
         8'd47:   ch = 7'h76;
         8'd48:   ch = 7'h62;
         8'd49:   ch = 7'h6E;
         8'd50:   ch = 7'h6D; // m
         8'd51:   ch = 7'h2C; // ,
         8'd52:   ch = 7'h2E; // .
         8'd53:   ch = 7'h2F; // /
         8'd55:   ch = 7'h2A; // keypad *
         8'd57:   ch = 7'h20; // space
         8'd71:   ch = 7'h37; // keypad 7
         8'd72:   ch = 7'h38;
         8'd73:   ch = 7'h39;
         8'd74:   ch = 7'h2D;
         8'd75:   ch = 7'h34;
         8'd76:   ch = 7'h35;
         8'd77:   ch = 7'h36;
         8'd78:   ch = 7'h2B;
         8'd79:   ch = 7'h31;
         8'd80:   ch = 7'h32;
         8'd81:   ch = 7'h33;
         8'd82:   ch = 7'h30;
         8'd83:   ch = 7'h2E; // keypad .
         default: ch = '0;
      endcase
      return ch;
   endfunction

   // shifted us layout
   function automatic logic [CHAR_W-1:0] shifted_char(input logic [SCAN_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      unique case (code)
         8'd2:    ch = 7'h21; // !
         8'd3:    ch = 7'h40; // @
         8'd4:    ch = 7'h23;
         8'd5:    ch = 7'h24;
         8'd6:    ch = 7'h25;
         8'd7:    ch = 7'h5E; // ^
         8'd8:    ch = 7'h26;
         8'd9:    ch = 7'h2A;
         8'd10:   ch = 7'h28;
         8'd11:   ch = 7'h29;
         8'd12:   ch = 7'h5F; // _
         8'd13:   ch = 7'h2B; // +
         8'd14:   ch = 7'h08;
         8'd15:   ch = 7'h09;
         8'd16:   ch = 7'h51; // Q
         8'd17:   ch = 7'h57;
         8'd18:   ch = 7'h45;
         8'd19:   ch = 7'h52;
         8'd20:   ch = 7'h54;
         8'd21:   ch = 7'h59;
         8'd22:   ch = 7'h55;
         8'd23:   ch = 7'h49;
         8'd24:   ch = 7'h4F;
         8'd25:   ch = 7'h50;
         8'd26:   ch = 7'h7B; // {
         8'd27:   ch = 7'h7D; // }
         8'd28:   ch = 7'h0A;
         8'd30:   ch = 7'h41; // A
         8'd31:   ch = 7'h53;
         8'd32:   ch = 7'h44;
         8'd33:   ch = 7'h46;
         8'd34:   ch = 7'h47;
         8'd35:   ch = 7'h48;
         8'd36:   ch = 7'h4A;
         8'd37:   ch = 7'h4B;
         8'd38:   ch = 7'h4C;
         8'd39:   ch = 7'h3A; // :
         8'd40:   ch = 7'h22; // double quote
         8'd41:   ch = 7'h7E; // ~
         8'd43:   ch = 7'h7C; // |
         8'd44:   ch = 7'h5A; // Z
         8'd45:   ch = 7'h58;
         8'd46:   ch = 7'h43;
         8'd47:   ch = 7'h56;
         8'd48:   ch = 7'h42;
         8'd49:   ch = 7'h4E;
         8'd50:   ch = 7'h4D;
         8'd51:   ch = 7'h3C; // <
         8'd52:   ch = 7'h3E; // >
         8'd53:   ch = 7'h3F; // ?
         8'd55:   ch = 7'h2A;
         8'd57:   ch = 7'h20;
         8'd71:   ch = 7'h37;
         8'd72:   ch = 7'h38;
         8'd73:   ch = 7'h39;
         8'd74:   ch = 7'h2D;
         8'd75:   ch = 7'h34;
         8'd76:   ch = 7'h35;
         8'd77:   ch = 7'h36;
         8'd78:   ch = 7'h2B;
         8'd79:   ch = 7'h31;
         8'd80:   ch = 7'h32;
         8'd81:   ch = 7'h33;
         8'd82:   ch = 7'h30;
         8'd83:   ch = 7'h2E;
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/s2a_lookup.sv
// s2a_lookup: combinational decode of one scancode against the held flags
// depends on s2a_pkg (constants, key map functions, flag and result types)

module s2a_lookup (
   input  logic [s2a_pkg::SCAN_W-1:0] scan_byte,
   input  s2a_pkg::flags_type         flags_cur,
   output s2a_pkg::result_type        result
);

   logic [s2a_pkg::CHAR_W-1:0] mapped;
   logic [s2a_pkg::CHAR_W-1:0] ch;
   logic                       is_lower;
   logic                       is_upper;
   s2a_pkg::flags_type         flags_nxt;

   always_comb begin
      mapped = flags_cur.shift ? s2a_pkg::shifted_char(scan_byte)
                               : s2a_pkg::plain_char(scan_byte);
      // letters under ctrl fold to control codes 1..26
      is_lower = (mapped >= 7'h61) && (mapped <= 7'h7A);
      is_upper = (mapped >= 7'h41) && (mapped <= 7'h5A);
      flags_nxt = flags_cur;
      ch        = '0;
      priority if (scan_byte == s2a_pkg::SCAN_LSHIFT_MAKE ||
                   scan_byte == s2a_pkg::SCAN_RSHIFT_MAKE) begin
         flags_nxt.shift = 1'b1;
      end else if (scan_byte == s2a_pkg::SCAN_LSHIFT_BREAK ||
                   scan_byte == s2a_pkg::SCAN_RSHIFT_BREAK) begin
         flags_nxt.shift = 1'b0;
      end else if (scan_byte == s2a_pkg::SCAN_CTRL_MAKE) begin
         flags_nxt.ctrl = 1'b1;
      end else if (scan_byte == s2a_pkg::SCAN_CTRL_BREAK) begin
         flags_nxt.ctrl = 1'b0;
      end else begin
         // release codes and out-of-range makes map to zero in the tables
         if (flags_cur.ctrl && (is_lower || is_upper)) begin
            ch = {2'b00, mapped[4:0]};
         end else begin
            ch = mapped;
         end
      end
   end

   assign result.char_valid = (ch != '0);
   assign result.ascii_char = ch;
   assign result.flags      = flags_nxt;

endmodule

FILE: sv/scancode_to_ascii_decoder_unit.sv
// scancode_to_ascii_decoder_unit: top level, input register, flag state and
// result register around s2a_lookup; depends on s2a_pkg and s2a_lookup
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------
//  req     | in  | req_tvalid/req_tready | tdata[7:0] scan_byte
//  rsp     | out | rsp_tvalid/rsp_tready | tdata[6:0] ascii_char, [7] shift_held,
//          |     |                       |  [8] ctrl_held; tuser char_valid
//
// one request per cycle sustained while rsp_tready is high; each request gives
// exactly one response, through input register, table lookup, result register
// reset is synchronous and active high: both flags clear, both stages empty
// a stalled response holds its register; the input register keeps taking a
// request whenever the result register is free or draining in the same cycle

module scancode_to_ascii_decoder_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,  // [7:0] scan_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [s2a_pkg::TDATA_W-1:0] rsp_tdata,  // [6:0] ascii_char, [7] shift_held,
                                                   // [8] ctrl_held, rest zero
   output logic                        rsp_tuser   // [0] char_valid
);

   // input stage
   logic                       in_valid_ff, in_valid_in;
   logic [s2a_pkg::SCAN_W-1:0] in_byte_ff, in_byte_in;

   // held flags, updated as each request moves into the result register
   s2a_pkg::flags_type         flags_ff, flags_in;

   // result stage
   logic                       out_valid_ff, out_valid_in;
   s2a_pkg::result_type        result_ff, result_in;

   s2a_pkg::result_type        decoded;
   logic                       req_accept;
   logic                       out_load;

   s2a_lookup u_lookup (
      .scan_byte (in_byte_ff),
      .flags_cur (flags_ff),
      .result    (decoded)
   );

   // result register is free when empty or being taken this cycle
   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_byte_in = req_accept ? req_tdata : in_byte_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (out_load) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      flags_in  = out_load ? decoded.flags : flags_ff;
      result_in = out_load ? decoded : result_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      result_ff  <= result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = result_ff.char_valid;
   assign rsp_tdata  = {{(s2a_pkg::TDATA_W - s2a_pkg::CHAR_W - 2){1'b0}},
                        result_ff.flags.ctrl,
                        result_ff.flags.shift,
                        result_ff.ascii_char};

endmodule

FILE: sv/s2a_checker.sv
// s2a_checker: port-level assertions for scancode_to_ascii_decoder_unit
// depends on s2a_pkg; bound to the top level at the end of this file

module s2a_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [s2a_pkg::TDATA_W-1:0] rsp_tdata,
   input logic                        rsp_tuser
);

   // response register is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // no character means a zero code, a character means a nonzero code
   a_char_valid_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == (rsp_tdata[6:0] != 7'h00)))
      else $error("char_valid disagrees with ascii_char");

   // with ctrl held, no letter leaves the block unfolded
   a_ctrl_folds_letters: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser && rsp_tdata[8]) |->
         !((rsp_tdata[6:0] >= 7'h61 && rsp_tdata[6:0] <= 7'h7A) ||
           (rsp_tdata[6:0] >= 7'h41 && rsp_tdata[6:0] <= 7'h5A)))
      else $error("letter not folded under ctrl");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[s2a_pkg::TDATA_W-1:9] == '0))
      else $error("response padding not zero");

   // a stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind scancode_to_ascii_decoder_unit s2a_checker u_s2a_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
